[design/atr_pkg.sv]
package atr_pkg;

	// scaling constants
	localparam int unsigned ACC_LIMIT = 31392;
	localparam int unsigned G_CENTI = 981;
	localparam int unsigned CPG_RESET = 16384;

	// angle limits in tenths of a degree
	localparam int ROLL_LIMIT = 1800;
	localparam int PITCH_LIMIT = 900;

	// cordic
	localparam int unsigned CORDIC_STEPS = 16;
	localparam int unsigned LUT_LEN = 24;
	localparam int unsigned CORD_STEPS = (CORDIC_STEPS > LUT_LEN) ? LUT_LEN : CORDIC_STEPS;
	localparam int unsigned DATA_W = 36;
	localparam int unsigned ANG_W = 29;
	localparam int unsigned OUT_ANG_W = 13;
	localparam int unsigned HALF_ROT = 1800 * 65536;

	// atan(2^-i) in tenths of a degree times 2^16
	localparam logic [24:0] ATAN_LUT [0:23] = '{
		25'd29491200, 25'd17409672, 25'd9198793, 25'd4669451,
		25'd2343786, 25'd1173036, 25'd586661, 25'd293348,
		25'd146676, 25'd73339, 25'd36669, 25'd18335,
		25'd9167, 25'd4584, 25'd2292, 25'd1146,
		25'd573, 25'd286, 25'd143, 25'd72,
		25'd36, 25'd18, 25'd9, 25'd4
	};

	// pipeline depths, the last stage is the angle clamp register
	localparam int unsigned DIV_BITS = 15;
	localparam int unsigned SCALE_LAT = DIV_BITS + 3;
	localparam int unsigned SQRT_LAT = 24;
	localparam int unsigned CORD_LAT = CORD_STEPS + 2;
	localparam int unsigned TOTAL_LAT = SCALE_LAT + SQRT_LAT + 3 + CORD_LAT + 1;
	localparam int unsigned AX_DLY = TOTAL_LAT - SCALE_LAT;
	localparam int unsigned ROOT_TAP = SQRT_LAT + 2;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} axes_t;

endpackage

[design/atr_scale.sv]
module atr_scale (
	input  logic               clk,
	input  logic               adv,
	input  logic        [15:0] cpg,
	input  logic signed [15:0] raw,
	output logic signed [15:0] acc
);

	localparam int unsigned NB = atr_pkg::DIV_BITS;

	logic signed [26:0] p_s1;
	logic        [24:0] abs_p;
	logic        [15:0] rem_s  [0:NB];
	logic        [NB-1:0] dvd_s [0:NB];
	logic        [NB-1:0] quo_s [0:NB];
	logic               neg_s  [0:NB];
	logic               sat_s  [0:NB];
	logic               zero_s [0:NB];
	logic        [15:0] qv;

	assign abs_p = p_s1[26] ? 25'(-p_s1) : p_s1[24:0];

	// product, then setup, then one quotient bit per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= 27'(raw) * 27'(atr_pkg::G_CENTI);
			rem_s[0] <= {6'd0, abs_p[24:NB]};
			dvd_s[0] <= abs_p[NB-1:0];
			quo_s[0] <= '0;
			neg_s[0] <= p_s1[26];
			sat_s[0] <= {6'd0, abs_p[24:NB]} >= cpg;
			zero_s[0] <= (cpg == 16'd0);
			for (int k = 0; k < NB; k++) begin
				logic [16:0] t;
				logic ge;
				t = {rem_s[k], dvd_s[k][NB-1]};
				ge = t >= {1'b0, cpg};
				rem_s[k+1] <= ge ? 16'(t - {1'b0, cpg}) : t[15:0];
				dvd_s[k+1] <= {dvd_s[k][NB-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][NB-2:0], ge};
				neg_s[k+1] <= neg_s[k];
				sat_s[k+1] <= sat_s[k];
				zero_s[k+1] <= zero_s[k];
			end
			acc <= neg_s[NB] ? -$signed(qv) : $signed(qv);
		end
	end

	// saturate and handle the zero divisor
	always_comb begin
		if (zero_s[NB])
			qv = '0;
		else if (sat_s[NB] || (16'(quo_s[NB]) > 16'(atr_pkg::ACC_LIMIT)))
			qv = 16'(atr_pkg::ACC_LIMIT);
		else
			qv = 16'(quo_s[NB]);
	end

endmodule

[design/atr_cordic.sv]
module atr_cordic (
	input  logic                                  clk,
	input  logic                                  adv,
	input  logic signed [atr_pkg::DATA_W-1:0]     y_in,
	input  logic signed [atr_pkg::DATA_W-1:0]     x_in,
	output logic signed [atr_pkg::OUT_ANG_W-1:0]  ang
);

	localparam int unsigned N = atr_pkg::CORD_STEPS;
	localparam int unsigned DW = atr_pkg::DATA_W;
	localparam int unsigned AW = atr_pkg::ANG_W;

	logic signed [DW-1:0] x_s [0:N];
	logic signed [DW-1:0] y_s [0:N];
	logic signed [AW-1:0] z_s [0:N];
	logic                 zero_s [0:N];
	logic signed [AW-1:0] zp;
	logic signed [AW-1:0] zm;

	assign zp = z_s[N] + AW'(32768);
	assign zm = -z_s[N] + AW'(32768);

	always_ff @(posedge clk) begin
		if (adv) begin
			// fold the left half plane
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in[DW-1]) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= y_in[DW-1] ? -AW'(atr_pkg::HALF_ROT) : AW'(atr_pkg::HALF_ROT);
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
			// one micro-rotation per stage
			for (int i = 0; i < N; i++) begin
				if (!y_s[i][DW-1] && (y_s[i] != '0)) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AW'(atr_pkg::ATAN_LUT[i]);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AW'(atr_pkg::ATAN_LUT[i]);
				end
				zero_s[i+1] <= zero_s[i];
			end
			// round to tenths, ties away from zero
			if (zero_s[N])
				ang <= '0;
			else if (!z_s[N][AW-1])
				ang <= zp[AW-1:16];
			else
				ang <= -zm[AW-1:16];
		end
	end

endmodule

[design/accel_tilt_roll_pitch.sv]
// throughput: one item per cycle while no result stalls; the scaling divider, square root and
// cordic are all one stage per bit or step, so every stage takes a new item
// a stalled result freezes the whole pipeline, sample_stall follows it
// reset clears all valid bits and sets counts_per_g to 16384
module accel_tilt_roll_pitch (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic        [15:0] cfg_wr_data,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [15:0] raw_x,
	input  logic signed [15:0] raw_y,
	input  logic signed [15:0] raw_z,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] accel_x_centi,
	output logic signed [15:0] accel_y_centi,
	output logic signed [15:0] accel_z_centi,
	output logic signed [11:0] roll_tenths,
	output logic signed [10:0] pitch_tenths
);

	localparam int unsigned TL = atr_pkg::TOTAL_LAT;
	localparam int unsigned AD = atr_pkg::AX_DLY;
	localparam int unsigned SL = atr_pkg::SQRT_LAT;
	localparam int unsigned RT = atr_pkg::ROOT_TAP;
	localparam int unsigned DW = atr_pkg::DATA_W;

	logic                 adv;
	logic        [15:0]   cpg_q;
	logic        [TL-1:0] vld_q;
	atr_pkg::axes_t       lane;
	atr_pkg::axes_t       axes_d [0:AD-1];
	logic        [29:0]   ysq_s1;
	logic        [29:0]   zsq_s1;
	logic        [30:0]   sum_s2;
	logic        [26:0]   rem_s  [0:SL];
	logic        [23:0]   root_s [0:SL];
	logic        [47:0]   rad_s  [0:SL];
	logic signed [31:0]   ysq;
	logic signed [31:0]   zsq;
	logic signed [DW-1:0] roll_y;
	logic signed [DW-1:0] roll_x;
	logic signed [DW-1:0] pitch_y;
	logic signed [DW-1:0] pitch_x;
	logic signed [atr_pkg::OUT_ANG_W-1:0] roll_c;
	logic signed [atr_pkg::OUT_ANG_W-1:0] pitch_c;

	// global pipeline advance
	assign adv = !(result_valid && result_stall);
	assign sample_stall = !adv;
	assign result_valid = vld_q[TL-1];

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpg_q <= 16'(atr_pkg::CPG_RESET);
		end else if (cfg_wr_en) begin
			cpg_q <= cfg_wr_data;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TL-2:0], sample_valid};
		end
	end

	// scale each axis to centi-m/s^2
	atr_scale u_scale_x (.clk(clk), .adv(adv), .cpg(cpg_q), .raw(raw_x), .acc(lane.x));
	atr_scale u_scale_y (.clk(clk), .adv(adv), .cpg(cpg_q), .raw(raw_y), .acc(lane.y));
	atr_scale u_scale_z (.clk(clk), .adv(adv), .cpg(cpg_q), .raw(raw_z), .acc(lane.z));

	assign ysq = 32'(lane.y) * 32'(lane.y);
	assign zsq = 32'(lane.z) * 32'(lane.z);

	// squares, sum and digit-by-digit square root
	always_ff @(posedge clk) begin
		if (adv) begin
			axes_d[0] <= lane;
			for (int k = 1; k < AD; k++) begin
				axes_d[k] <= axes_d[k-1];
			end
			ysq_s1 <= ysq[29:0];
			zsq_s1 <= zsq[29:0];
			sum_s2 <= {1'b0, ysq_s1} + {1'b0, zsq_s1};
			rem_s[0] <= '0;
			root_s[0] <= '0;
			rad_s[0] <= {1'b0, sum_s2, 16'd0};
			for (int j = 0; j < SL; j++) begin
				logic [26:0] t;
				logic [26:0] trial;
				logic ge;
				t = {rem_s[j][24:0], rad_s[j][47:46]};
				trial = {1'b0, root_s[j], 2'b01};
				ge = t >= trial;
				rem_s[j+1] <= ge ? (t - trial) : t;
				root_s[j+1] <= {root_s[j][22:0], ge};
				rad_s[j+1] <= {rad_s[j][45:0], 2'b00};
			end
		end
	end

	// cordic operands, both in units of 2^-16
	assign roll_y = {{4{axes_d[RT].y[15]}}, axes_d[RT].y, 16'd0};
	assign roll_x = {{4{axes_d[RT].z[15]}}, axes_d[RT].z, 16'd0};
	assign pitch_y = -{{4{axes_d[RT].x[15]}}, axes_d[RT].x, 16'd0};
	assign pitch_x = {4'd0, root_s[SL], 8'd0};

	atr_cordic u_roll  (.clk(clk), .adv(adv), .y_in(roll_y),  .x_in(roll_x),  .ang(roll_c));
	atr_cordic u_pitch (.clk(clk), .adv(adv), .y_in(pitch_y), .x_in(pitch_x), .ang(pitch_c));

	// clamp angles into the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			if (roll_c > 13'(atr_pkg::ROLL_LIMIT))
				roll_tenths <= 12'(atr_pkg::ROLL_LIMIT);
			else if (roll_c < -13'(atr_pkg::ROLL_LIMIT))
				roll_tenths <= -12'(atr_pkg::ROLL_LIMIT);
			else
				roll_tenths <= roll_c[11:0];
			if (pitch_c > 13'(atr_pkg::PITCH_LIMIT))
				pitch_tenths <= 11'(atr_pkg::PITCH_LIMIT);
			else if (pitch_c < -13'(atr_pkg::PITCH_LIMIT))
				pitch_tenths <= -11'(atr_pkg::PITCH_LIMIT);
			else
				pitch_tenths <= pitch_c[10:0];
		end
	end

	assign accel_x_centi = axes_d[AD-1].x;
	assign accel_y_centi = axes_d[AD-1].y;
	assign accel_z_centi = axes_d[AD-1].z;

	// checks
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (roll_tenths <= 12'sd1800) && (roll_tenths >= -12'sd1800)
			&& (pitch_tenths <= 11'sd900) && (pitch_tenths >= -11'sd900))
		else $error("angle out of range");

	a_roll_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (accel_y_centi == 16'sd0) && (accel_z_centi == 16'sd0))
			|-> (roll_tenths == 12'sd0))
		else $error("roll of zero vector not zero");

	a_pitch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (accel_x_centi == 16'sd0) && (accel_y_centi == 16'sd0)
			&& (accel_z_centi == 16'sd0)) |-> (pitch_tenths == 11'sd0))
		else $error("pitch of zero vector not zero");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

endmodule
